// ===== hw/rtl/slm_pkg.sv =====
package slm_pkg;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 12;
  localparam int FLOOR_W  = 12;
  localparam int THR_W    = 13;
  localparam int GAIN_W   = 8;
  localparam int WEIGHT_W = 9;
  localparam int RAW_W    = 16;
  localparam int SMOOTH_W = 20;
  localparam int MIX_W    = 29;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int QUEUE_DEPTH_DEF = 2;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_BASELINE    = 3'd0;
  localparam logic [2:0] REG_SQUELCH     = 3'd1;
  localparam logic [2:0] REG_DEADZONE    = 3'd2;
  localparam logic [2:0] REG_THRESHOLD   = 3'd3;
  localparam logic [2:0] REG_GAIN        = 3'd4;
  localparam logic [2:0] REG_SMOOTHING   = 3'd5;

  localparam logic [FLOOR_W-1:0]  BASELINE_RST    = 12'd600;
  localparam logic [FLOOR_W-1:0]  SQUELCH_RST     = 12'd100;
  localparam logic [FLOOR_W-1:0]  DEADZONE_RST    = 12'd175;
  localparam logic [THR_W-1:0]    THRESHOLD_RST   = 13'd25;
  localparam logic [GAIN_W-1:0]   GAIN_RST        = 8'd48;
  localparam logic [WEIGHT_W-1:0] SMOOTHING_RST   = 9'd51;

  localparam logic [RAW_W-1:0]    RAW_MAX_Q4 = 16'd65520;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 12'd4095;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                window_end;
  } slm_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               changed;
  } slm_out_t;

  typedef struct packed {
    logic [FLOOR_W-1:0]  baseline;
    logic [FLOOR_W-1:0]  squelch;
    logic [FLOOR_W-1:0]  deadzone;
    logic [THR_W-1:0]    change_threshold;
    logic [GAIN_W-1:0]   gain_q4_4;
    logic [WEIGHT_W-1:0] smoothing_q0_8;
  } slm_cfg_t;

endpackage

// ===== hw/rtl/slm_queue.sv =====
module slm_queue #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/slm_front.sv =====
module slm_front
  import slm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  slm_in_t                in_data,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [SAMPLE_BITS-1:0] q_data
);

  localparam int EXT_W = SAMPLE_BITS + SAMPLE_W;

  logic [SAMPLE_BITS-1:0] window_max;
  logic [SAMPLE_BITS-1:0] window_min;
  logic [SAMPLE_BITS-1:0] max_next;
  logic [SAMPLE_BITS-1:0] min_next;
  logic [EXT_W-1:0]       s_ext;
  logic [SAMPLE_BITS-1:0] s;
  logic                   accept;

  assign s_ext    = EXT_W'(in_data.sample);
  assign s        = s_ext[SAMPLE_BITS-1:0];
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && in_data.window_end;

  always_comb begin
    max_next = (s > window_max) ? s : window_max;
    min_next = (s < window_min) ? s : window_min;
    q_data   = (max_next >= min_next) ? (max_next - min_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_max <= '0;
      window_min <= '1;
    end else if (accept) begin
      if (in_data.window_end) begin
        window_max <= '0;
        window_min <= '1;
      end else begin
        window_max <= max_next;
        window_min <= min_next;
      end
    end
  end

`ifndef SYNTH
  a_window_restart: assert property (@(posedge clk) disable iff (rst)
    $past(q_push) |-> (window_max == '0 && window_min == '1))
    else $error("window not restarted after close");
`endif

endmodule

// ===== hw/rtl/slm_back.sv =====
module slm_back
  import slm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  slm_cfg_t               cfg,
  input  logic                   q_empty,
  input  logic [SAMPLE_BITS-1:0] q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output slm_out_t               out_data
);

  localparam int ADJ_W  = (SAMPLE_BITS > FLOOR_W) ? SAMPLE_BITS : FLOOR_W;
  localparam int PROD_W = ADJ_W + GAIN_W;
  localparam int RND_W  = SMOOTH_W + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GAIN = 3'd1;
  localparam logic [2:0] ST_WNEW = 3'd2;
  localparam logic [2:0] ST_MIX  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [ADJ_W-1:0]    adj;
  logic [ADJ_W-1:0]    adj_next;
  logic [ADJ_W-1:0]    p2p_ext;
  logic [PROD_W-1:0]   gain_prod;
  logic [RAW_W-1:0]    raw;
  logic [MIX_W-1:0]    new_part;
  logic [MIX_W-1:0]    acc;
  logic [SMOOTH_W-1:0] smoothed_level;
  logic [WEIGHT_W-1:0] w;
  logic [RND_W-1:0]    rnd;
  logic [LEVEL_W:0]    lvl_wide;
  logic [LEVEL_W-1:0]  lvl;
  logic [LEVEL_W-1:0]  last_reported;
  logic                has_last;
  logic [THR_W-1:0]    mag;
  logic                changed;
  logic                load;

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign load  = (state == ST_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    p2p_ext = ADJ_W'(q_data);
    adj_next = (p2p_ext > ADJ_W'(cfg.baseline)) ? (p2p_ext - ADJ_W'(cfg.baseline)) : '0;
    if (adj_next < ADJ_W'(cfg.squelch)) begin
      adj_next = '0;
    end
    gain_prod = PROD_W'(adj) * PROD_W'(cfg.gain_q4_4);
    w = (cfg.smoothing_q0_8 > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smoothing_q0_8;
    // average takes w parts new value and 256 - w parts old, rounded half up
    acc = new_part + MIX_W'(WEIGHT_ONE - w) * MIX_W'(smoothed_level) + MIX_W'(128);
    rnd = RND_W'(smoothed_level) + RND_W'(128);
    lvl_wide = rnd[RND_W-1:8];
    lvl = (lvl_wide > (LEVEL_W+1)'(LEVEL_MAX)) ? LEVEL_MAX : lvl_wide[LEVEL_W-1:0];
    if (lvl < cfg.deadzone) begin
      lvl = '0;
    end
    // no level flagged yet behaves as a last level of minus one
    if (!has_last) begin
      mag = THR_W'(lvl) + 1'b1;
    end else if (lvl >= last_reported) begin
      mag = THR_W'(lvl - last_reported);
    end else begin
      mag = THR_W'(last_reported - lvl);
    end
    changed = (mag >= cfg.change_threshold);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_empty) state_next = ST_GAIN;
      ST_GAIN: state_next = ST_WNEW;
      ST_WNEW: state_next = ST_MIX;
      ST_MIX:  state_next = ST_EMIT;
      ST_EMIT: if (load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      adj <= adj_next;
    end
    if (state == ST_GAIN) begin
      raw <= (gain_prod > PROD_W'(RAW_MAX_Q4)) ? RAW_MAX_Q4 : gain_prod[RAW_W-1:0];
    end
    if (state == ST_WNEW) begin
      new_part <= MIX_W'(w) * MIX_W'({raw, 4'b0000});
    end
    if (load) begin
      out_data.level   <= lvl;
      out_data.changed <= changed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      smoothed_level <= '0;
      has_last       <= 1'b0;
      last_reported  <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MIX) begin
        smoothed_level <= acc[SMOOTH_W+7:8];
      end
      if (load && changed) begin
        has_last      <= 1'b1;
        last_reported <= lvl;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_deadzone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.level != '0) |-> (out_data.level >= cfg.deadzone))
    else $error("level below deadzone reported");
  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    load |=> (state == ST_IDLE && out_valid))
    else $error("result load did not return to idle");
`endif

endmodule

// ===== hw/rtl/sound_level_meter_unit.sv =====
// channel   dir  signals                         item
// in        in   in_valid, in_stall, in_data     one sample, window_end closes window
// out       out  out_valid, out_stall, out_data  level and changed, one per window
// cfg       in   psel, penable, pwrite, paddr    six registers at 4 * index
//
// samples enter one a cycle unless stalled; a closing sample queues its peak-to-peak
// the back end works each window through adjust, gain multiply, two mix multiplies,
// round and compare; in_stall rises only while the queue holds QUEUE_DEPTH windows
// out_data sits in a register, so a stalled output holds the back end, not the samples
// rst is synchronous and restores the register defaults and clears window and average
module sound_level_meter_unit
  import slm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  slm_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output slm_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  slm_cfg_t               cfg;
  logic                   wr_en;
  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;
  logic [SAMPLE_BITS-1:0] push_data;
  logic [SAMPLE_BITS-1:0] pop_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.baseline         <= BASELINE_RST;
      cfg.squelch          <= SQUELCH_RST;
      cfg.deadzone         <= DEADZONE_RST;
      cfg.change_threshold <= THRESHOLD_RST;
      cfg.gain_q4_4        <= GAIN_RST;
      cfg.smoothing_q0_8   <= SMOOTHING_RST;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_BASELINE:    cfg.baseline         <= pwdata[FLOOR_W-1:0];
        REG_SQUELCH:     cfg.squelch          <= pwdata[FLOOR_W-1:0];
        REG_DEADZONE:    cfg.deadzone         <= pwdata[FLOOR_W-1:0];
        REG_THRESHOLD:   cfg.change_threshold <= pwdata[THR_W-1:0];
        REG_GAIN:        cfg.gain_q4_4        <= pwdata[GAIN_W-1:0];
        REG_SMOOTHING:   cfg.smoothing_q0_8   <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_BASELINE:    prdata = DATA_W'(cfg.baseline);
      REG_SQUELCH:     prdata = DATA_W'(cfg.squelch);
      REG_DEADZONE:    prdata = DATA_W'(cfg.deadzone);
      REG_THRESHOLD:   prdata = DATA_W'(cfg.change_threshold);
      REG_GAIN:        prdata = DATA_W'(cfg.gain_q4_4);
      REG_SMOOTHING:   prdata = DATA_W'(cfg.smoothing_q0_8);
      default:         prdata = '0;
    endcase
  end

  slm_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (push_data)
  );

  slm_queue #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  slm_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
